FILE: rtl/btki_pkg.sv
// Package for the banked top-K insertion block.
// Holds payload structs, status codes, controller/datapath command and status structs.
// No dependencies.
package btki_pkg;

	localparam int NUM_BANKS_DEF  = 6;
	localparam int KEEP_DEPTH_DEF = 10;

	localparam int BANK_W = 3;
	localparam int COST_W = 32;
	localparam int TAG_W  = 32;
	localparam int CNT_W  = 4;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_BAD_BANK = 2'd2
	} status_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  owner_tag;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] rank;
		logic [CNT_W-1:0] bank_count;
	} out_item_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  owner;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic accept;      // latch the offered item, read the bank tail
		logic step;        // shift entry up one slot, read the next lower one
		logic shift_last;  // shift entry zero up; new entry goes to slot zero
		logic reject;      // full bank and cost not below the worst
		logic place_next;  // write the new entry just above the current slot
		logic place_zero;  // write the new entry to slot zero
		logic load;        // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_bad;      // offered bank is out of range
		logic in_empty;    // offered bank holds no entries
		logic shift;       // read entry costs more than the new one
		logic at_tail;     // scan index sits on the last slot of the bank
		logic at_head;     // scan index sits on slot zero
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage

FILE: rtl/btki_ctrl.sv
// Controller for the banked top-K insertion block.
// One-hot state machine issuing btki_pkg::cmd_t from btki_pkg::sts_t.
// Depends on btki_pkg.
module btki_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  btki_pkg::sts_t sts,
	output btki_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_PLACE  = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.in_bad) begin
						state_d = S_RESULT;
					end else if (sts.in_empty) begin
						state_d = S_PLACE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.shift) begin
					if (sts.at_head) begin
						cmd.shift_last = 1'b1;
						state_d        = S_PLACE;
					end else begin
						cmd.step = 1'b1;
					end
				end else if (sts.at_tail) begin
					cmd.reject = 1'b1;
					state_d    = S_RESULT;
				end else begin
					cmd.place_next = 1'b1;
					state_d        = S_RESULT;
				end
			end
			S_PLACE: begin
				cmd.place_zero = 1'b1;
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/btki_dpath.sv
// Datapath for the banked top-K insertion block.
// Holds the entry store, per-bank fill counts, scan registers and the output register.
// Depends on btki_pkg.
module btki_dpath #(
	parameter int NUM_BANKS  = btki_pkg::NUM_BANKS_DEF,
	parameter int KEEP_DEPTH = btki_pkg::KEEP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btki_pkg::in_item_t  in_item,
	input  btki_pkg::cmd_t      cmd,
	output btki_pkg::sts_t      sts,
	output logic                out_valid,
	input  logic                out_stall,
	output btki_pkg::out_item_t out_item
);

	localparam int SLOTS  = NUM_BANKS * KEEP_DEPTH;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BIDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int CNT_W  = btki_pkg::CNT_W;

	localparam logic [CNT_W-1:0] TAIL_IDX  = CNT_W'(KEEP_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(KEEP_DEPTH);

	btki_pkg::entry_t mem_q [SLOTS];
	btki_pkg::entry_t rd_q;

	logic [CNT_W-1:0] fill_q [NUM_BANKS];

	logic [btki_pkg::BANK_W-1:0] bank_q;
	logic [btki_pkg::COST_W-1:0] cost_q;
	logic [btki_pkg::TAG_W-1:0]  owner_q;
	logic [CNT_W-1:0]            count_q;
	logic [ADDR_W-1:0]           base_q;
	logic [CNT_W-1:0]            j_q;
	logic [CNT_W-1:0]            pos_q;
	btki_pkg::status_t           status_q;

	btki_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic                in_bad;
	logic [CNT_W-1:0]    in_fill;
	logic [ADDR_W-1:0]   in_base;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	btki_pkg::entry_t    wr_data;
	logic [ADDR_W-1:0]   above_addr;
	logic [CNT_W-1:0]    new_count;
	btki_pkg::out_item_t result;

	assign in_bad  = {1'b0, in_item.bank} >= (btki_pkg::BANK_W + 1)'(NUM_BANKS);
	assign in_fill = fill_q[in_item.bank[BIDX_W-1:0]];
	assign in_base = ADDR_W'(in_item.bank) * ADDR_W'(KEEP_DEPTH);

	assign above_addr = base_q + ADDR_W'(j_q + CNT_W'(1));

	assign sts.in_bad   = in_bad;
	assign sts.in_empty = !in_bad && (in_fill == '0);
	assign sts.shift    = rd_q.cost > cost_q;
	assign sts.at_tail  = (j_q == TAIL_IDX);
	assign sts.at_head  = (j_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	// read side: tail of the bank on accept, next lower slot while shifting
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = base_q + ADDR_W'(j_q - CNT_W'(1));
		if (cmd.accept) begin
			rd_en   = !in_bad && (in_fill != '0);
			rd_addr = in_base + ADDR_W'(in_fill - CNT_W'(1));
		end else if (cmd.step) begin
			rd_en = 1'b1;
		end
	end

	// write side: the worst entry of a full bank is not written back (dropped)
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = above_addr;
		wr_data = rd_q;
		if (cmd.step || cmd.shift_last) begin
			wr_en = !sts.at_tail;
		end else if (cmd.place_next) begin
			wr_en   = 1'b1;
			wr_data = '{cost: cost_q, owner: owner_q};
		end else if (cmd.place_zero) begin
			wr_en   = 1'b1;
			wr_addr = base_q;
			wr_data = '{cost: cost_q, owner: owner_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// scan and item registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bank_q   <= in_item.bank;
			cost_q   <= in_item.cost;
			owner_q  <= in_item.owner_tag;
			count_q  <= in_fill;
			base_q   <= in_base;
			j_q      <= in_fill - CNT_W'(1);
			pos_q    <= '0;
			status_q <= in_bad ? btki_pkg::ST_BAD_BANK : btki_pkg::ST_INSERTED;
		end else begin
			if (cmd.step) begin
				j_q <= j_q - CNT_W'(1);
			end
			if (cmd.place_next) begin
				pos_q <= j_q + CNT_W'(1);
			end
			if (cmd.reject) begin
				status_q <= btki_pkg::ST_REJECTED;
			end
		end
	end

	always_comb begin
		new_count = count_q;
		if (status_q == btki_pkg::ST_INSERTED && count_q != FULL_CNT) begin
			new_count = count_q + CNT_W'(1);
		end
		result.status     = status_q;
		result.rank       = (status_q == btki_pkg::ST_INSERTED) ? pos_q : '0;
		result.bank_count = (status_q == btki_pkg::ST_BAD_BANK) ? '0 : new_count;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int b = 0; b < NUM_BANKS; b++) begin
				fill_q[b] <= '0;
			end
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load && status_q == btki_pkg::ST_INSERTED) begin
				fill_q[bank_q[BIDX_W-1:0]] <= new_count;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: rtl/banked_top_k_insert.sv
// Order from input transfer to result valid: the scan state compares the kept entries one at a
// time, the place state writes the entry when it lands in slot zero, the result state loads it.
// A new item is taken only once the result of the last one is loaded; the scan reads one
// stored entry per cycle through the single read port of the entry store, shifting as it goes.
// Reset: arst_n clears the controller, the output valid flag and all bank fill counts (every
// bank empty); the entry store is not cleared, so no clearing pass is needed after reset.
module banked_top_k_insert #(
	parameter int NUM_BANKS  = btki_pkg::NUM_BANKS_DEF,
	parameter int KEEP_DEPTH = btki_pkg::KEEP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  btki_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output btki_pkg::out_item_t out_item
);

	// Command and status between the sequencer and the datapath.
	btki_pkg::cmd_t cmd_w;
	btki_pkg::sts_t sts_w;

	// Sequencer: take one transfer in idle, walk the bank from its tail towards
	// slot zero, then hold the result until the output register is free.
	btki_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts_w),
		.cmd      (cmd_w)
	);

	// Datapath: entry store, fill counts and the output register. The output
	// register parts the result side from the input side, so a new transfer is
	// taken while a finished result still waits.
	btki_dpath #(
		.NUM_BANKS  (NUM_BANKS),
		.KEEP_DEPTH (KEEP_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd_w),
		.sts       (sts_w),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	// A result load always shows up on the output the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.load |=> out_valid)
		else $error("result load did not reach the output");

	// An inserted entry ranks inside the bank it now belongs to.
	a_rank_in_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == btki_pkg::ST_INSERTED
		|-> out_item.rank < out_item.bank_count)
		else $error("insert rank beyond bank count");

	// A bad bank leaves a zero rank and count.
	a_bad_bank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == btki_pkg::ST_BAD_BANK
		|-> out_item.rank == '0 && out_item.bank_count == '0)
		else $error("bad bank result carries rank or count");

	// No bank ever reports more than KEEP_DEPTH entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.bank_count <= btki_pkg::CNT_W'(KEEP_DEPTH))
		else $error("bank count above depth");
`endif

endmodule

FILE: dv/banked_top_k_insert_tb.sv
// Self-checking testbench for banked_top_k_insert: directed table, then random inserts.
// Keeps its own sorted copy of every bank to forecast status, rank and fill count.
// Depends on btki_pkg and the banked_top_k_insert RTL.
module banked_top_k_insert_tb;

	localparam int NB          = btki_pkg::NUM_BANKS_DEF;
	localparam int KD          = btki_pkg::KEEP_DEPTH_DEF;
	localparam int BW          = btki_pkg::BANK_W;
	localparam int CW          = btki_pkg::CNT_W;
	localparam int RAND_ITEMS  = 1930;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		btki_pkg::in_item_t  item;
		bit                  typed;
		btki_pkg::out_item_t want;
	} table_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	btki_pkg::in_item_t  in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	btki_pkg::out_item_t out_item;

	// Own copy of the banks: costs and owners in ascending cost order.
	logic [btki_pkg::COST_W-1:0] kept_cost  [NB][KD];
	logic [btki_pkg::TAG_W-1:0]  kept_owner [NB][KD];
	int                          kept_fill  [NB];

	btki_pkg::out_item_t awaited_outcomes [$];
	table_row_t          directed_rows [$];
	int                  mismatches     = 0;
	int                  cycle_count    = 0;
	bit                  sender_idles   = 1'b1;
	bit                  receiver_idles = 1'b1;
	bit                  hold_request   = 1'b0;

	banked_top_k_insert #(
		.NUM_BANKS (NB),
		.KEEP_DEPTH(KD)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Forecast the outcome of offering one entry and update the bank copy to match.
	function automatic btki_pkg::out_item_t rank_entry(input btki_pkg::in_item_t it);
		btki_pkg::out_item_t r;
		int                  b;
		int                  n;
		int                  pos;
		int                  i;
		r = '0;
		if (it.bank >= NB) begin
			r.status = btki_pkg::ST_BAD_BANK;
			return r;
		end
		b = int'(it.bank);
		n = kept_fill[b];
		// Full bank: only a cost strictly below the worst gets in.
		if (n == KD && !(it.cost < kept_cost[b][KD-1])) begin
			r.status     = btki_pkg::ST_REJECTED;
			r.bank_count = CW'(n);
			return r;
		end
		// Land after every kept entry of equal or lower cost.
		pos = 0;
		while (pos < n && kept_cost[b][pos] <= it.cost)
			pos++;
		// Shift the tail up one slot; a full bank drops its worst entry.
		for (i = (n < KD) ? n : n - 1; i > pos; i--) begin
			kept_cost[b][i]  = kept_cost[b][i-1];
			kept_owner[b][i] = kept_owner[b][i-1];
		end
		kept_cost[b][pos]  = it.cost;
		kept_owner[b][pos] = it.owner_tag;
		if (n < KD)
			n++;
		kept_fill[b] = n;
		r.status     = btki_pkg::ST_INSERTED;
		r.rank       = CW'(pos);
		r.bank_count = CW'(n);
		return r;
	endfunction

	function automatic void add_row(input int bank, input logic [btki_pkg::COST_W-1:0] cost,
			input logic [btki_pkg::TAG_W-1:0] owner, input bit typed,
			input btki_pkg::status_t status, input int rank, input int count);
		table_row_t row;
		row.item.bank       = BW'(bank);
		row.item.cost       = cost;
		row.item.owner_tag  = owner;
		row.typed           = typed;
		row.want.status     = status;
		row.want.rank       = CW'(rank);
		row.want.bank_count = CW'(count);
		directed_rows.push_back(row);
	endfunction

	// Offer one item, after a random gap when the sender idles, hold it until the transfer, then record
	// the expected outcome. Called just after a rising edge.
	task automatic offer_item(input btki_pkg::in_item_t it, input bit typed,
			input btki_pkg::out_item_t want);
		int                  gap;
		btki_pkg::out_item_t forecast;
		gap = sender_idles ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		// Hold the payload while the block stalls its input.
		while (in_stall)
			@(posedge clk);
		// Advance the bank copy on every row; a typed row overrides the forecast.
		forecast = rank_entry(it);
		awaited_outcomes.push_back(typed ? want : forecast);
	endtask

	task automatic drain_outcomes;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: draw a wait per result, or take a long hold-off when asked, then
	// keep stall low until a result transfer happens.
	initial begin : result_receiver
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				wait_cycles  = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				wait_cycles = receiver_idles ? $urandom_range(0, 7) : 0;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Compare each result transfer with the oldest outcome still awaited.
	always @(posedge clk) begin : result_check
		btki_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result status %0d rank %0d count %0d", $time,
					out_item.status, out_item.rank, out_item.bank_count);
			end else begin
				want = awaited_outcomes.pop_front();
				if (out_item.status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_item.status);
				end
				if (out_item.rank !== want.rank) begin
					mismatches++;
					$display("%0t: rank expected %0d actual %0d", $time,
						want.rank, out_item.rank);
				end
				if (out_item.bank_count !== want.bank_count) begin
					mismatches++;
					$display("%0t: bank_count expected %0d actual %0d", $time,
						want.bank_count, out_item.bank_count);
				end
			end
		end
	end

	// Watchdog: give up well beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		btki_pkg::in_item_t  it;
		btki_pkg::out_item_t none;
		int                  b;
		int                  pick;
		int                  mode;
		none = '0;

		// Directed table: out-of-range banks, extremes, ties, a full bank.
		add_row(7, 32'hFFFF_FFFF, 32'h0000_0000, 1, btki_pkg::ST_BAD_BANK, 0, 0);
		add_row(6, 32'h0000_0000, 32'hFFFF_FFFF, 1, btki_pkg::ST_BAD_BANK, 0, 0);
		add_row(0, 32'h0000_0000, 32'h0000_0001, 1, btki_pkg::ST_INSERTED, 0, 1);
		add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, btki_pkg::ST_INSERTED, 1, 2);
		add_row(0, 32'h0000_0000, 32'h0000_0002, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd50,        32'h0000_0010, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd40,        32'h0000_0011, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd30,        32'h0000_0012, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd20,        32'h0000_0013, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd10,        32'h0000_0014, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd40,        32'h0000_0015, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'd1000,      32'h0000_0016, 0, btki_pkg::ST_INSERTED, 0, 0);
		// Bank 0 is full now with the all-ones cost as its worst.
		add_row(0, 32'hFFFF_FFFF, 32'h0000_0003, 1, btki_pkg::ST_REJECTED, 0, KD);
		add_row(0, 32'hFFFF_FFFE, 32'hA5A5_5A5A, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(0, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 1, btki_pkg::ST_REJECTED, 0, KD);
		add_row(0, 32'h0000_0000, 32'h0000_0004, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(5, 32'd7,         32'h1234_5678, 1, btki_pkg::ST_INSERTED, 0, 1);
		add_row(3, 32'h8000_0000, 32'h8765_4321, 1, btki_pkg::ST_INSERTED, 0, 1);
		add_row(1, 32'd12345,     32'hDEAD_0001, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(2, 32'h7FFF_FFFF, 32'hDEAD_0002, 0, btki_pkg::ST_INSERTED, 0, 0);
		add_row(4, 32'h0000_0001, 32'hDEAD_0003, 0, btki_pkg::ST_INSERTED, 0, 0);

		// Hold reset, then release it on an edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		// Pause the sender until every outcome so far has come back.
		in_valid <= 1'b0;
		drain_outcomes();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// Switch idling mode every 150 transfers, with stretches of none.
			if (n % 150 == 0) begin
				mode           = $urandom_range(0, 3);
				sender_idles   = mode[0];
				receiver_idles = mode[1];
			end
			// Long receiver hold-off while the sender keeps offering.
			if (n == 600)
				hold_request = 1'b1;
			// Let everything drain once more midway.
			if (n == 1200) begin
				in_valid <= 1'b0;
				drain_outcomes();
			end

			b = ($urandom_range(0, 99) < 8) ? $urandom_range(NB, 7) : $urandom_range(0, NB - 1);
			it.bank      = BW'(b);
			it.owner_tag = $urandom();
			pick         = $urandom_range(0, 9);
			case (pick)
				0, 1: begin
					it.cost = $urandom();
				end
				2, 3, 4: begin
					it.cost = $urandom_range(0, 63);
				end
				5: begin
					it.cost = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				end
				6, 7: begin
					// Beat the worst of a full bank so that the drop path is exercised.
					if (b < NB && kept_fill[b] == KD && kept_cost[b][KD-1] != 0)
						it.cost = $urandom_range(0, kept_cost[b][KD-1] - 1);
					else
						it.cost = $urandom_range(0, 1000);
				end
				8: begin
					// Tie with a kept cost, including the worst.
					if (b < NB && kept_fill[b] > 0)
						it.cost = kept_cost[b][$urandom_range(0, kept_fill[b] - 1)];
					else
						it.cost = $urandom();
				end
				default: begin
					it.cost = $urandom_range(0, 1000);
				end
			endcase
			offer_item(it, 1'b0, none);
		end

		in_valid <= 1'b0;
		drain_outcomes();
		// Allow for a late stray result beyond the longest scan.
		repeat (4 * (KD + 3)) @(posedge clk);
		if (mismatches == 0 && awaited_outcomes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
